// ----- sv/nine_patch_rect_split_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef NINE_PATCH_RECT_SPLIT_MACROS_SVH
`define NINE_PATCH_RECT_SPLIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define NPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property that is also checked during reset.
`define NPS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/nps_pkg.sv -----
package nps_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_NINE     = 2'd0;
   localparam logic [1:0] MODE_THREE_H  = 2'd1;
   localparam logic [1:0] MODE_THREE_V  = 2'd2;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   localparam logic [2:0] CSR_LAYOUT        = 3'd0;
   localparam logic [2:0] CSR_BORDER_LEFT   = 3'd1;
   localparam logic [2:0] CSR_BORDER_RIGHT  = 3'd2;
   localparam logic [2:0] CSR_BORDER_TOP    = 3'd3;
   localparam logic [2:0] CSR_BORDER_BOTTOM = 3'd4;

   localparam logic [3:0] LAST_NINE  = 4'd8;
   localparam logic [3:0] LAST_THREE = 4'd2;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_FIT,
      FS_MUL,
      FS_DIV,
      FS_DONE,
      FS_PUSH
   } front_state_type;

   typedef struct packed {
      logic [1:0]  layout_mode;
      logic [15:0] border_left;
      logic [15:0] border_right;
      logic [15:0] border_top;
      logic [15:0] border_bottom;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        src_x;
      logic [15:0]        src_y;
      logic [15:0]        src_w;
      logic [15:0]        src_h;
      logic signed [15:0] dst_x;
      logic signed [15:0] dst_y;
      logic signed [15:0] dst_w;
      logic signed [15:0] dst_h;
   } req_type;

   // One classified item: origins plus the three part lengths of each axis (Q.8).
   typedef struct packed {
      logic [1:0]         layout_mode;
      logic [15:0]        src_x;
      logic [15:0]        src_y;
      logic signed [15:0] dst_x;
      logic signed [15:0] dst_y;
      logic [2:0][23:0]   src_col;
      logic [2:0][22:0]   dst_col;
      logic [2:0][23:0]   src_row;
      logic [2:0][22:0]   dst_row;
   } entry_type;

endpackage

// ----- sv/nps_req_if.sv -----
interface nps_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        src_x;
   logic [15:0]        src_y;
   logic [15:0]        src_w;
   logic [15:0]        src_h;
   logic signed [15:0] dst_x;
   logic signed [15:0] dst_y;
   logic signed [15:0] dst_w;
   logic signed [15:0] dst_h;

   modport source (output valid, src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w, dst_h,
                   input ready);
   modport sink (input valid, src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w, dst_h,
                 output ready);
endinterface

// ----- sv/nps_rsp_if.sv -----
interface nps_rsp_if;
   logic               valid;
   logic               ready;
   logic [24:0]        patch_src_x;
   logic [24:0]        patch_src_y;
   logic [23:0]        patch_src_w;
   logic [23:0]        patch_src_h;
   logic signed [24:0] patch_dst_x;
   logic signed [24:0] patch_dst_y;
   logic [22:0]        patch_dst_w;
   logic [22:0]        patch_dst_h;
   logic [3:0]         patch_index;
   logic               last_patch;

   modport source (output valid, patch_src_x, patch_src_y, patch_src_w, patch_src_h,
                   patch_dst_x, patch_dst_y, patch_dst_w, patch_dst_h, patch_index,
                   last_patch, input ready);
   modport sink (input valid, patch_src_x, patch_src_y, patch_src_w, patch_src_h,
                 patch_dst_x, patch_dst_y, patch_dst_w, patch_dst_h, patch_index,
                 last_patch, output ready);
   modport monitor (input valid, ready, patch_src_x, patch_src_y, patch_src_w, patch_src_h,
                    patch_dst_x, patch_dst_y, patch_dst_w, patch_dst_h, patch_index,
                    last_patch);
endinterface

// ----- sv/nine_patch_rect_split.sv -----
// Nine-slice rectangle splitter.
// req_chan takes one source/destination rectangle pair per item; rsp_chan
// returns its patches in row-major order, nine for the nine-patch layout and
// three for either three-patch layout, last_patch marking the final one.
// A destination with zero or negative width or height, or an unused layout
// code, gives no patches. The user must write borders and layout on the csr_
// port only while no item is in flight; the block itself does not enforce it.
// The back end sends one patch per cycle while the queue holds items and
// rsp_chan.ready stays high. Each border pair that must be scaled (source and
// destination fits, per axis) runs a 24-step shared divider pair in the front
// end.
// A queue of QDepth classified items decouples the two halves; when the
// receiver stalls, the output register holds its patch, the queue fills and
// req_chan.ready drops once the front end's holding register is occupied.
// Reset (synchronous, active high) clears the configuration to zero and
// empties the pipeline.
module nine_patch_rect_split
   import nps_pkg::*;
#(
   parameter int QDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   nps_req_if.sink     req_chan,
   nps_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LAYOUT:        cfg_in.layout_mode   = csr_wdata[1:0];
            CSR_BORDER_LEFT:   cfg_in.border_left   = csr_wdata;
            CSR_BORDER_RIGHT:  cfg_in.border_right  = csr_wdata;
            CSR_BORDER_TOP:    cfg_in.border_top    = csr_wdata;
            CSR_BORDER_BOTTOM: cfg_in.border_bottom = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   nps_queue #(.Depth(QDepth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   nps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_chan)
   );

endmodule

// ----- sv/nps_front.sv -----
module nps_front
   import nps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   nps_req_if.sink   req,
   input  cfg_type   cfg,
   output logic      push_valid,
   input  logic      push_ready,
   output entry_type push_data
);

   front_state_type state_ff, state_in;
   logic            in_valid_ff, in_valid_in;
   req_type         in_ff, in_in;
   req_type         cur_ff, cur_in;
   entry_type       entry_ff, entry_in;
   logic            axis_ff, axis_in;       // 0 columns, 1 rows
   logic            dst_phase_ff, dst_phase_in;
   logic [23:0]     b0_ff, b0_in, b1_ff, b1_in, t_ff, t_in;
   logic [24:0]     den_ff, den_in;
   logic [24:0]     rem0_ff, rem0_in, rem1_ff, rem1_in;
   logic [23:0]     lo0_ff, lo0_in, lo1_ff, lo1_in;
   logic [23:0]     q0_ff, q0_in, q1_ff, q1_in;
   logic [4:0]      cnt_ff, cnt_in;

   logic [24:0] s_sum;
   logic [47:0] prod0, prod1;
   logic [25:0] trial0, trial1;
   logic        ge0, ge1;
   logic        commit;
   logic [23:0] ca0, ca1, len1;
   logic        in_bad;

   assign req.ready  = !in_valid_ff;
   assign push_valid = (state_ff == FS_PUSH);
   assign push_data  = entry_ff;

   assign s_sum  = {1'b0, b0_ff} + {1'b0, b1_ff};
   assign prod0  = b0_ff * t_ff;
   assign prod1  = b1_ff * t_ff;
   assign trial0 = {rem0_ff, lo0_ff[23]};
   assign trial1 = {rem1_ff, lo1_ff[23]};
   assign ge0    = trial0 >= {1'b0, den_ff};
   assign ge1    = trial1 >= {1'b0, den_ff};
   assign in_bad = in_ff.dst_w[15] || (in_ff.dst_w == 16'sd0) ||
                   in_ff.dst_h[15] || (in_ff.dst_h == 16'sd0) ||
                   (cfg.layout_mode != MODE_NINE && cfg.layout_mode != MODE_THREE_H &&
                    cfg.layout_mode != MODE_THREE_V);

   always_comb begin
      commit = 1'b0;
      ca0    = b0_ff;
      ca1    = b1_ff;
      if (state_ff == FS_FIT && !(s_sum > {1'b0, t_ff})) begin
         commit = 1'b1;
      end else if (state_ff == FS_DONE) begin
         commit = 1'b1;
         ca0    = q0_ff;
         ca1    = q1_ff;
      end
      len1 = t_ff - ca0 - ca1;
   end

   always_comb begin
      state_in     = state_ff;
      in_valid_in  = in_valid_ff;
      in_in        = in_ff;
      cur_in       = cur_ff;
      entry_in     = entry_ff;
      axis_in      = axis_ff;
      dst_phase_in = dst_phase_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      t_in         = t_ff;
      den_in       = den_ff;
      rem0_in      = rem0_ff;
      rem1_in      = rem1_ff;
      lo0_in       = lo0_ff;
      lo1_in       = lo1_ff;
      q0_in        = q0_ff;
      q1_in        = q1_ff;
      cnt_in       = cnt_ff;

      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         in_in = '{req.src_x, req.src_y, req.src_w, req.src_h,
                   req.dst_x, req.dst_y, req.dst_w, req.dst_h};
      end

      unique case (state_ff)
         FS_IDLE: begin
            if (in_valid_ff) begin
               in_valid_in = 1'b0;
               if (!in_bad) begin
                  cur_in               = in_ff;
                  entry_in.layout_mode = cfg.layout_mode;
                  entry_in.src_x       = in_ff.src_x;
                  entry_in.src_y       = in_ff.src_y;
                  entry_in.dst_x       = in_ff.dst_x;
                  entry_in.dst_y       = in_ff.dst_y;
                  // unsplit axis keeps the full span in part 0
                  entry_in.src_col = {24'd0, 24'd0, {in_ff.src_w, 8'h00}};
                  entry_in.src_row = {24'd0, 24'd0, {in_ff.src_h, 8'h00}};
                  entry_in.dst_col = {23'd0, 23'd0, {in_ff.dst_w[14:0], 8'h00}};
                  entry_in.dst_row = {23'd0, 23'd0, {in_ff.dst_h[14:0], 8'h00}};
                  dst_phase_in = 1'b0;
                  if (cfg.layout_mode != MODE_THREE_V) begin
                     axis_in = 1'b0;
                     b0_in   = {cfg.border_left, 8'h00};
                     b1_in   = {cfg.border_right, 8'h00};
                     t_in    = {in_ff.src_w, 8'h00};
                  end else begin
                     axis_in = 1'b1;
                     b0_in   = {cfg.border_top, 8'h00};
                     b1_in   = {cfg.border_bottom, 8'h00};
                     t_in    = {in_ff.src_h, 8'h00};
                  end
                  state_in = FS_FIT;
               end
            end
         end
         FS_FIT: begin
            if (!commit) begin
               state_in = FS_MUL;
            end
         end
         FS_MUL: begin
            den_in   = s_sum;
            rem0_in  = {1'b0, prod0[47:24]};
            rem1_in  = {1'b0, prod1[47:24]};
            lo0_in   = prod0[23:0];
            lo1_in   = prod1[23:0];
            cnt_in   = 5'd0;
            state_in = FS_DIV;
         end
         FS_DIV: begin
            rem0_in = ge0 ? 25'(trial0 - {1'b0, den_ff}) : trial0[24:0];
            rem1_in = ge1 ? 25'(trial1 - {1'b0, den_ff}) : trial1[24:0];
            lo0_in  = {lo0_ff[22:0], 1'b0};
            lo1_in  = {lo1_ff[22:0], 1'b0};
            q0_in   = {q0_ff[22:0], ge0};
            q1_in   = {q1_ff[22:0], ge1};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd23) begin
               state_in = FS_DONE;
            end
         end
         FS_DONE: begin
         end
         FS_PUSH: begin
            if (push_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase

      if (commit) begin
         if (!dst_phase_ff) begin
            if (!axis_ff) begin
               entry_in.src_col = {ca1, len1, ca0};
               t_in = {1'b0, cur_ff.dst_w[14:0], 8'h00};
            end else begin
               entry_in.src_row = {ca1, len1, ca0};
               t_in = {1'b0, cur_ff.dst_h[14:0], 8'h00};
            end
            b0_in        = ca0;
            b1_in        = ca1;
            dst_phase_in = 1'b1;
            state_in     = FS_FIT;
         end else begin
            if (!axis_ff) begin
               entry_in.dst_col = {ca1[22:0], len1[22:0], ca0[22:0]};
            end else begin
               entry_in.dst_row = {ca1[22:0], len1[22:0], ca0[22:0]};
            end
            if (!axis_ff && entry_ff.layout_mode != MODE_THREE_H) begin
               axis_in      = 1'b1;
               dst_phase_in = 1'b0;
               b0_in        = {cfg.border_top, 8'h00};
               b1_in        = {cfg.border_bottom, 8'h00};
               t_in         = {cur_ff.src_h, 8'h00};
               state_in     = FS_FIT;
            end else begin
               state_in = FS_PUSH;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FS_IDLE;
         in_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_valid_ff <= in_valid_in;
      end
      in_ff        <= in_in;
      cur_ff       <= cur_in;
      entry_ff     <= entry_in;
      axis_ff      <= axis_in;
      dst_phase_ff <= dst_phase_in;
      b0_ff        <= b0_in;
      b1_ff        <= b1_in;
      t_ff         <= t_in;
      den_ff       <= den_in;
      rem0_ff      <= rem0_in;
      rem1_ff      <= rem1_in;
      lo0_ff       <= lo0_in;
      lo1_ff       <= lo1_in;
      q0_ff        <= q0_in;
      q1_ff        <= q1_in;
      cnt_ff       <= cnt_in;
   end

endmodule

// ----- sv/nps_queue.sv -----
module nps_queue
   import nps_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type         mem_ff [Depth];
   logic [PtrW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PtrW'(Depth - 1)) ? '0 : wptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PtrW'(Depth - 1)) ? '0 : rptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/nps_back.sv -----
module nps_back
   import nps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  entry_type pop_data,
   nps_rsp_if.source rsp
);

   logic [1:0]  row_ff, row_in, col_ff, col_in;
   logic [3:0]  k_ff, k_in;
   logic        out_valid_ff, out_valid_in;
   logic [24:0] osx_ff, osy_ff;
   logic [23:0] osw_ff, osh_ff;
   logic [24:0] odx_ff, ody_ff;
   logic [22:0] odw_ff, odh_ff;
   logic [3:0]  ok_ff;
   logic        olast_ff;

   logic        load, last_col, last_row, last;
   logic [23:0] scoff, sroff;
   logic [22:0] dcoff, droff;
   logic [24:0] psx, psy, pdx, pdy;

   assign load     = pop_valid && (!out_valid_ff || rsp.ready);
   assign last_col = (pop_data.layout_mode == MODE_THREE_V) || (col_ff == 2'd2);
   assign last_row = (pop_data.layout_mode == MODE_THREE_H) || (row_ff == 2'd2);
   assign last     = last_col && last_row;
   assign pop_ready = load && last;

   always_comb begin
      case (col_ff)
         2'd0:    begin scoff = '0; dcoff = '0; end
         2'd1:    begin scoff = pop_data.src_col[0]; dcoff = pop_data.dst_col[0]; end
         default: begin
            scoff = pop_data.src_col[0] + pop_data.src_col[1];
            dcoff = pop_data.dst_col[0] + pop_data.dst_col[1];
         end
      endcase
      case (row_ff)
         2'd0:    begin sroff = '0; droff = '0; end
         2'd1:    begin sroff = pop_data.src_row[0]; droff = pop_data.dst_row[0]; end
         default: begin
            sroff = pop_data.src_row[0] + pop_data.src_row[1];
            droff = pop_data.dst_row[0] + pop_data.dst_row[1];
         end
      endcase
      psx = {1'b0, pop_data.src_x, 8'h00} + {1'b0, scoff};
      psy = {1'b0, pop_data.src_y, 8'h00} + {1'b0, sroff};
      pdx = {{1{pop_data.dst_x[15]}}, pop_data.dst_x, 8'h00} + {2'b00, dcoff};
      pdy = {{1{pop_data.dst_y[15]}}, pop_data.dst_y, 8'h00} + {2'b00, droff};
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      out_valid_in = out_valid_ff;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         if (last) begin
            row_in = '0;
            col_in = '0;
            k_in   = '0;
         end else begin
            k_in = k_ff + 4'd1;
            if (last_col) begin
               col_in = '0;
               row_in = row_ff + 2'd1;
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         osx_ff   <= psx;
         osy_ff   <= psy;
         osw_ff   <= pop_data.src_col[col_ff];
         osh_ff   <= pop_data.src_row[row_ff];
         odx_ff   <= pdx;
         ody_ff   <= pdy;
         odw_ff   <= pop_data.dst_col[col_ff];
         odh_ff   <= pop_data.dst_row[row_ff];
         ok_ff    <= k_ff;
         olast_ff <= last;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.patch_src_x = osx_ff;
   assign rsp.patch_src_y = osy_ff;
   assign rsp.patch_src_w = osw_ff;
   assign rsp.patch_src_h = osh_ff;
   assign rsp.patch_dst_x = odx_ff;
   assign rsp.patch_dst_y = ody_ff;
   assign rsp.patch_dst_w = odw_ff;
   assign rsp.patch_dst_h = odh_ff;
   assign rsp.patch_index = ok_ff;
   assign rsp.last_patch  = olast_ff;

endmodule

// ----- sv/nps_checker.sv -----
`include "nine_patch_rect_split_macros.svh"

module nps_checker
   import nps_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_patch_index,
   input logic       rsp_last_patch
);

   `NPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
   `NPS_ASSERT(a_last_index, rsp_valid && rsp_last_patch |-> (rsp_patch_index == LAST_NINE || rsp_patch_index == LAST_THREE), "last patch at wrong index")
   `NPS_ASSERT(a_next_index, rsp_valid && rsp_ready && !rsp_last_patch ##1 rsp_valid |-> rsp_patch_index == $past(rsp_patch_index) + 4'd1, "patch index skipped")
   `NPS_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind nine_patch_rect_split nps_checker u_nps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_patch_index (rsp_chan.patch_index),
   .rsp_last_patch  (rsp_chan.last_patch)
);
